// ----- design/kmer_node_table_core_macros.svh -----
// assertion macros for the k-mer node table
`ifndef KMER_NODE_TABLE_CORE_MACROS_SVH
`define KMER_NODE_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KNT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KNT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/knt_pkg.sv -----
// shared constants, codes and types of the k-mer node table
package knt_pkg;

    localparam int MAX_K      = 31;
    localparam int KEY_W      = 2 * MAX_K;
    localparam int K_W        = 5;
    localparam int RUN_W      = 5;
    localparam int NODE_W     = 17;
    localparam int MAX_NODES  = 65536;
    localparam int NODE_AW    = $clog2(MAX_NODES);
    localparam int HASH_SLOTS = 131072;
    localparam int SLOT_W     = $clog2(HASH_SLOTS);
    localparam int HASH_SHR   = 29;
    localparam int PROD_W     = HASH_SHR + SLOT_W;
    localparam int HALF_W     = PROD_W / 2;
    localparam int DEG_W      = 3;

    localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_MAP  = 2'd1,
        KIND_DEG  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DKEY,
        ST_HASH,
        ST_PROBE,
        ST_PWAIT,
        ST_KWAIT,
        ST_DONE,
        ST_RESULT
    } t_state;

endpackage

// ----- design/knt_if.sv -----
// valid/ready channel interfaces of the k-mer node table
interface knt_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [1:0]                  base;
    logic                        base_valid;
    logic                        seq_start;
    logic [knt_pkg::NODE_W-1:0]  query_node;

    modport source (output valid, kind, base, base_valid, seq_start, query_node, input ready);
    modport sink   (input valid, kind, base, base_valid, seq_start, query_node, output ready);
endinterface

interface knt_out_if;
    logic                        valid;
    logic                        ready;
    logic [knt_pkg::NODE_W-1:0]  node_id;
    logic [knt_pkg::DEG_W-1:0]   out_degree;
    logic [knt_pkg::DEG_W-1:0]   in_degree;
    logic                        table_full;

    modport source (output valid, node_id, out_degree, in_degree, table_full, input ready);
    modport sink   (input valid, node_id, out_degree, in_degree, table_full, output ready);
endinterface

interface knt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [knt_pkg::K_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/kmer_node_table_core.sv -----
// k-mer node table: hash table of k-mers numbered in insertion order
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------
//  i_in     | in  | kind, base, base_valid, seq_start, query_node
//  o_out    | out | node_id, out_degree, in_degree, table_full
//  i_cfg    | in  | data = kmer_length (always ready)
//
// one item at a time; a base that completes no window ends in the accept state;
// an add or map lookup passes the accept state, the hash states, a probe, read
// wait and key compare per occupied slot probed (probe and read wait for the
// empty slot that ends a miss), a done and a result state, though an add that
// finds its k-mer gives no result; a degree query on a stored node passes the
// accept, key read, eight lookups (hash, probes, done) and result states.
// reset and every kmer_length write start a clearing pass over the slot
// memory during which i_in is not ready; i_in is also held off while a
// kmer_length write is offered.
// o_out is a register: the next item is taken while a result waits.
`include "kmer_node_table_core_macros.svh"

module kmer_node_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    knt_in_if.sink     i_in,
    knt_out_if.source  o_out,
    knt_cfg_if.sink    i_cfg
);
    import knt_pkg::*;

    t_state              r_state, n_state;
    logic [K_W-1:0]      r_k;
    logic [KEY_W-1:0]    r_win, r_key, r_qkey, r_key_q;
    logic [RUN_W-1:0]    r_run;
    logic [NODE_W-1:0]   r_cnt, r_q, r_slot_q;
    t_kind               r_kind;
    logic [1:0]          r_hstep;
    logic [PROD_W-1:0]   r_acc;
    logic [SLOT_W-1:0]   r_slot, r_clr, r_nprobe;
    logic                r_hit, r_free;
    logic [2:0]          r_cand;
    logic [DEG_W-1:0]    r_od, r_id, r_res_od, r_res_id, r_o_od, r_o_id;
    logic [NODE_W-1:0]   r_res_node, r_o_node;
    logic                r_res_full, r_o_full, r_ovalid;

    logic [NODE_W-1:0]   slot_mem [HASH_SLOTS];
    logic [KEY_W-1:0]    key_mem  [MAX_NODES];

    logic                in_fire, cfg_fire, out_free;
    logic                is_base, q_bad, key_eq, last_probe;
    logic [KEY_W-1:0]    mask, win_new;
    logic [RUN_W-1:0]    run_base, run_new;
    logic                win_full;
    logic [5:0]          top;
    logic                key_re, key_we, slot_we;
    logic [NODE_AW-1:0]  key_raddr;
    logic [SLOT_W-1:0]   slot_waddr;
    logic [NODE_W-1:0]   slot_wdata;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic [DEG_W-1:0]    od_n, id_n;
    logic [K_W-1:0]      k_clamp;

    // successor or predecessor of a node key, chosen by candidate index
    function automatic logic [KEY_W-1:0] cand_key(input logic [KEY_W-1:0] qk,
                                                  input logic [2:0] idx,
                                                  input logic [KEY_W-1:0] m,
                                                  input logic [5:0] sh);
        logic [KEY_W-1:0] cext;
        cext = {{(KEY_W-2){1'b0}}, idx[2:1]};
        if (!idx[0]) begin
            return ((qk << 2) | cext) & m;
        end
        return ((cext << sh) | (qk >> 2)) & m;
    endfunction

    // handshakes
    assign in_fire    = i_in.valid && i_in.ready;
    assign cfg_fire   = i_cfg.valid && i_cfg.ready;
    assign out_free   = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = 1'b1;

    // key mask from k
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            mask[2*i +: 2] = (K_W'(i) < r_k) ? 2'b11 : 2'b00;
        end
    end
    assign top = {r_k - 5'd1, 1'b0};

    // window update for an incoming base
    assign is_base  = (i_in.kind == KIND_ADD) || (i_in.kind == KIND_MAP);
    assign run_base = i_in.seq_start ? '0 : r_run;
    assign run_new  = (run_base < r_k) ? run_base + 1'b1 : run_base;
    assign win_new  = ((r_win << 2) | {{(KEY_W-2){1'b0}}, i_in.base}) & mask;
    assign win_full = (run_new >= r_k);
    assign q_bad    = (i_in.query_node == '0) || (i_in.query_node > r_cnt);

    // probe compare
    assign key_eq     = (r_key_q == r_key);
    assign last_probe = (r_nprobe == SLOT_W'(HASH_SLOTS - 1));

    // degree counters
    assign od_n = r_od + {{(DEG_W-1){1'b0}}, r_hit && !r_cand[0]};
    assign id_n = r_id + {{(DEG_W-1){1'b0}}, r_hit && r_cand[0]};

    // hash multiplier: low bits of key times constant, in three partial products
    always_comb begin
        case (r_hstep)
            2'd1: begin
                mul_a = r_key[2*HALF_W-1:HALF_W];
                mul_b = HASH_MUL[HALF_W-1:0];
            end
            2'd2: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = HASH_MUL[2*HALF_W-1:HALF_W];
            end
            default: begin
                mul_a = r_key[HALF_W-1:0];
                mul_b = HASH_MUL[HALF_W-1:0];
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // memory port control
    assign key_re    = (in_fire && (i_in.kind == KIND_DEG) && !q_bad) ||
                       ((r_state == ST_PWAIT) && (r_slot_q != '0));
    assign key_raddr = (r_state == ST_IDLE) ? NODE_AW'(i_in.query_node - 1'b1)
                                            : NODE_AW'(r_slot_q - 1'b1);
    assign key_we    = (r_state == ST_DONE) && (r_kind == KIND_ADD) && !r_hit &&
                       r_free && (r_cnt < NODE_W'(MAX_NODES));
    assign slot_we    = (r_state == ST_CLEAR) || key_we;
    assign slot_waddr = (r_state == ST_CLEAR) ? r_clr : r_slot;
    assign slot_wdata = (r_state == ST_CLEAR) ? '0 : r_cnt + 1'b1;

    assign k_clamp = (i_cfg.data == '0) ? K_W'(1) :
                     (i_cfg.data > K_W'(MAX_K)) ? K_W'(MAX_K) : i_cfg.data;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_base && i_in.base_valid && win_full) begin
                        n_state = ST_HASH;
                    end else if (i_in.kind == KIND_DEG) begin
                        n_state = q_bad ? ST_RESULT : ST_DKEY;
                    end
                end
            end
            ST_DKEY:  n_state = ST_HASH;
            ST_HASH: begin
                if (r_hstep == 2'd3) n_state = ST_PROBE;
            end
            ST_PROBE: n_state = ST_PWAIT;
            ST_PWAIT: n_state = (r_slot_q == '0) ? ST_DONE : ST_KWAIT;
            ST_KWAIT: n_state = (key_eq || last_probe) ? ST_DONE : ST_PROBE;
            ST_DONE: begin
                case (r_kind)
                    KIND_ADD: n_state = r_hit ? ST_IDLE : ST_RESULT;
                    KIND_DEG: n_state = (r_cand == 3'd7) ? ST_RESULT : ST_HASH;
                    default:  n_state = ST_RESULT;
                endcase
            end
            ST_RESULT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
        if (cfg_fire) n_state = ST_CLEAR;
    end

    // control registers: config, window, node count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= K_W'(MAX_K);
            r_run    <= '0;
            r_win    <= '0;
            r_cnt    <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_RESULT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_fire) begin
                r_k   <= k_clamp;
                r_cnt <= '0;
                r_run <= '0;
                r_win <= '0;
                r_clr <= '0;
            end else begin
                if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
                if (in_fire && is_base) begin
                    if (!i_in.base_valid) begin
                        r_run <= '0;
                    end else begin
                        r_win <= win_new;
                        r_run <= run_new;
                    end
                end
                if (key_we) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath registers per state
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_kind     <= t_kind'(i_in.kind);
                    r_q        <= i_in.query_node;
                    r_key      <= win_new;
                    r_hstep    <= '0;
                    r_cand     <= '0;
                    r_od       <= '0;
                    r_id       <= '0;
                    r_res_node <= '0;
                    r_res_od   <= '0;
                    r_res_id   <= '0;
                    r_res_full <= 1'b0;
                end
            end
            ST_DKEY: begin
                r_qkey  <= r_key_q;
                r_key   <= cand_key(r_key_q, 3'd0, mask, top);
                r_hstep <= '0;
            end
            ST_HASH: begin
                r_hstep <= r_hstep + 1'b1;
                case (r_hstep)
                    2'd0: r_acc <= prod;
                    2'd3: begin
                        r_slot   <= r_acc[SLOT_W-1:0] ^ r_acc[PROD_W-1 -: SLOT_W];
                        r_nprobe <= '0;
                    end
                    default: r_acc <= r_acc + (prod << HALF_W);
                endcase
            end
            ST_PWAIT: begin
                if (r_slot_q == '0) begin
                    r_hit  <= 1'b0;
                    r_free <= 1'b1;
                end
            end
            ST_KWAIT: begin
                if (key_eq) begin
                    r_hit <= 1'b1;
                end else if (last_probe) begin
                    r_hit  <= 1'b0;
                    r_free <= 1'b0;
                end else begin
                    r_slot   <= r_slot + 1'b1;
                    r_nprobe <= r_nprobe + 1'b1;
                end
            end
            ST_DONE: begin
                case (r_kind)
                    KIND_MAP: r_res_node <= r_hit ? r_slot_q : '0;
                    KIND_ADD: begin
                        if (key_we) begin
                            r_res_node <= r_cnt + 1'b1;
                        end else begin
                            r_res_full <= 1'b1;
                        end
                    end
                    default: begin
                        r_od       <= od_n;
                        r_id       <= id_n;
                        r_res_od   <= od_n;
                        r_res_id   <= id_n;
                        r_res_node <= r_q;
                        r_cand     <= r_cand + 1'b1;
                        r_key      <= cand_key(r_qkey, r_cand + 1'b1, mask, top);
                        r_hstep    <= '0;
                    end
                endcase
            end
            ST_RESULT: begin
                if (out_free) begin
                    r_o_node <= r_res_node;
                    r_o_od   <= r_res_od;
                    r_o_id   <= r_res_id;
                    r_o_full <= r_res_full;
                end
            end
            default: begin
            end
        endcase
    end

    // slot memory read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PROBE) r_slot_q <= slot_mem[r_slot];
    end

    // slot memory write: clearing pass or new node
    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    end

    // key memory read
    always_ff @(posedge i_clk) begin
        if (key_re) r_key_q <= key_mem[key_raddr];
    end

    // key memory write at the next node number
    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[r_cnt[NODE_AW-1:0]] <= r_key;
    end

    // output beat
    assign o_out.valid      = r_ovalid;
    assign o_out.node_id    = r_o_node;
    assign o_out.out_degree = r_o_od;
    assign o_out.in_degree  = r_o_id;
    assign o_out.table_full = r_o_full;

    // checks
    `KNT_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= NODE_W'(MAX_NODES), "node count above capacity")
    `KNT_ASSERT_IMP(a_ins_room, key_we, !r_hit && (r_cnt < NODE_W'(MAX_NODES)), "bad insert")
    `KNT_ASSERT_NXT(a_cnt_step, !cfg_fire,
                    (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + 1'b1),
                    "node count jumped")
    `KNT_ASSERT_IMP(a_clear_hold, r_state == ST_CLEAR, !i_in.ready && !key_we, "item taken during clear")
    `KNT_ASSERT_NXT(a_out_load, (r_state == ST_RESULT) && out_free, r_ovalid, "result beat lost")

endmodule

// ----- tb/tb_kmer_node_table_core.sv -----
// testbench of the k-mer node table: directed table, then random base runs
module tb_kmer_node_table_core;
    import knt_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [DEG_W-1:0]  out_degree;
        logic [DEG_W-1:0]  in_degree;
        logic              table_full;
    } t_result;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        base;
        logic              base_valid;
        logic              seq_start;
        logic [NODE_W-1:0] query_node;
        logic              typed;
        t_result           res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    knt_in_if  in_ch();
    knt_out_if out_ch();
    knt_cfg_if cfg_ch();

    kmer_node_table_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    int unsigned  kmer_len = MAX_K;
    logic [63:0]  window_kmer = '0;
    int unsigned  run_len = 0;
    int unsigned  node_of_kmer[logic [63:0]];
    logic [63:0]  kmer_of_node[$];
    t_result      pending_results[$];

    int     fail_count = 0;
    int     idle_cycles = 0;
    bit     no_idle = 0;
    bit     row_typed = 0;
    t_result row_res;
    int     ready_hold = 0;
    logic [1:0] genome[80];

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic logic [63:0] kmer_mask();
        return (64'd1 << (2 * kmer_len)) - 64'd1;
    endfunction

    function automatic bit kmer_stored(input logic [63:0] key);
        return node_of_kmer.exists(key);
    endfunction

    // expected results of one accepted beat
    function automatic void predict_beat(input t_kind kind, input logic [1:0] base,
                                         input logic bv, input logic ss,
                                         input logic [NODE_W-1:0] q);
        t_result r;
        logic [63:0] key, nxt, prv, msk;
        int unsigned top;
        r = '0;
        msk = kmer_mask();
        if (kind == KIND_DEG) begin
            if (q != 0 && q <= kmer_of_node.size()) begin
                key = kmer_of_node[q-1];
                top = 2 * (kmer_len - 1);
                for (int c = 0; c < 4; c++) begin
                    nxt = ((key << 2) | 64'(c)) & msk;
                    prv = ((64'(c) << top) | (key >> 2)) & msk;
                    if (kmer_stored(nxt)) r.out_degree++;
                    if (kmer_stored(prv)) r.in_degree++;
                end
                r.node_id = q;
            end
            pending_results = {pending_results, r};
            return;
        end
        if (kind == KIND_NONE) return;
        if (ss) run_len = 0;
        if (!bv) begin
            run_len = 0;
            return;
        end
        window_kmer = ((window_kmer << 2) | 64'(base)) & msk;
        if (run_len < kmer_len) run_len++;
        if (run_len < kmer_len) return;
        if (kind == KIND_MAP) begin
            if (kmer_stored(window_kmer)) r.node_id = node_of_kmer[window_kmer];
            pending_results = {pending_results, r};
            return;
        end
        if (kmer_stored(window_kmer)) return;
        if (kmer_of_node.size() >= MAX_NODES) begin
            r.table_full = 1'b1;
        end else begin
            kmer_of_node = {kmer_of_node, window_kmer};
            node_of_kmer[window_kmer] = kmer_of_node.size();
            r.node_id = kmer_of_node.size();
        end
        pending_results = {pending_results, r};
    endfunction

    // checker, predictor feed and watchdog
    always @(posedge i_clk) begin
        t_result got, want;
        int unsigned k;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.node_id, out_ch.out_degree, out_ch.in_degree, out_ch.table_full};
                if (pending_results.size() == 0) begin
                    report($sformatf("unexpected beat node %0d", got.node_id));
                end else begin
                    want = pending_results.pop_front();
                    if (got.node_id !== want.node_id)
                        report($sformatf("node_id %0d, want %0d", got.node_id, want.node_id));
                    if (got.out_degree !== want.out_degree)
                        report($sformatf("out_degree %0d, want %0d",
                                         got.out_degree, want.out_degree));
                    if (got.in_degree !== want.in_degree)
                        report($sformatf("in_degree %0d, want %0d",
                                         got.in_degree, want.in_degree));
                    if (got.table_full !== want.table_full)
                        report($sformatf("table_full %0d, want %0d",
                                         got.table_full, want.table_full));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_beat(t_kind'(in_ch.kind), in_ch.base, in_ch.base_valid,
                             in_ch.seq_start, in_ch.query_node);
                // directed rows carry their own expectation
                if (row_typed) begin
                    if (pending_results.size() == 0) begin
                        report("directed row gave no prediction");
                    end else begin
                        pending_results[pending_results.size() - 1] = row_res;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                k = cfg_ch.data;
                if (k == 0) k = 1;
                if (k > MAX_K) k = MAX_K;
                kmer_len = k;
                node_of_kmer.delete();
                kmer_of_node.delete();
                window_kmer = '0;
                run_len = 0;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 400000) begin
                $display("[kmer_node_table_core] ERROR");
                $finish;
            end
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        int r;
        if (no_idle) begin
            out_ch.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end else begin
            r = $urandom_range(99);
            if (r < 10) ready_hold = $urandom_range(3, 1);
            else if (r < 13) ready_hold = $urandom_range(40, 10);
            out_ch.ready <= (r >= 13);
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(50, 10);
    endfunction

    // one beat on the input channel, driven at the falling edge
    task automatic send_beat(input t_row row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= row.kind;
        in_ch.base       <= row.base;
        in_ch.base_valid <= row.base_valid;
        in_ch.seq_start  <= row.seq_start;
        in_ch.query_node <= row.query_node;
        row_typed = row.typed;
        row_res   = row.res;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        row_typed = 1'b0;
    endtask

    // drain results, let the block settle, then write kmer_length
    task automatic write_kmer_len(input logic [K_W-1:0] value);
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (120) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_row base_row(input t_kind kind, input logic [1:0] base,
                                      input logic bv, input logic ss);
        t_row row;
        row = '0;
        row.kind = kind;
        row.base = base;
        row.base_valid = bv;
        row.seq_start = ss;
        return row;
    endfunction

    // random part: runs cut from a short genome, plus queries and noise
    task automatic random_phase(input int beats);
        t_row row;
        int sent, pos, len, r;
        t_kind kind;
        sent = 0;
        foreach (genome[i]) genome[i] = 2'($urandom_range(3));
        while (sent < beats) begin
            r = $urandom_range(99);
            if (sent > beats / 2 && sent < beats / 2 + 40 && r < 3) begin
                in_ch.valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
            no_idle = ($urandom_range(9) == 0);
            if (r < 70) begin
                len = $urandom_range(kmer_len + 12, kmer_len);
                if (len > 80) len = 80;
                pos = $urandom_range(80 - len);
                kind = ($urandom_range(2) == 0) ? KIND_MAP : KIND_ADD;
                for (int i = 0; i < len; i++) begin
                    row = base_row(kind, genome[pos + i], 1'b1, i == 0);
                    if ($urandom_range(40) == 0) row.base = 2'($urandom_range(3));
                    row.query_node = NODE_W'($urandom);
                    send_beat(row);
                    sent++;
                end
            end else if (r < 88) begin
                row = base_row(KIND_DEG, 2'($urandom_range(3)), 1'($urandom), 1'($urandom));
                if (kmer_of_node.size() > 0 && $urandom_range(4) != 0)
                    row.query_node = NODE_W'($urandom_range(kmer_of_node.size(), 1));
                else
                    row.query_node = NODE_W'($urandom);
                send_beat(row);
                sent++;
            end else begin
                row = base_row(t_kind'($urandom_range(3)), 2'($urandom_range(3)),
                               1'($urandom_range(3) != 0), 1'($urandom));
                row.query_node = NODE_W'($urandom);
                send_beat(row);
                sent++;
            end
        end
        no_idle = 0;
    endtask

    // directed rows at kmer_length 2
    t_row directed[] = '{
        '{KIND_DEG, 2'd0, 1'b0, 1'b0, 17'd0,     1'b1, '{17'd0, 3'd0, 3'd0, 1'b0}},
        '{KIND_DEG, 2'd3, 1'b1, 1'b1, 17'd65536, 1'b1, '{17'd0, 3'd0, 3'd0, 1'b0}},
        '{KIND_ADD, 2'd0, 1'b1, 1'b1, 17'd0,     1'b0, '0},
        '{KIND_ADD, 2'd1, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd1, 3'd0, 3'd0, 1'b0}},
        '{KIND_ADD, 2'd0, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd2, 3'd0, 3'd0, 1'b0}},
        '{KIND_ADD, 2'd1, 1'b1, 1'b0, 17'd0,     1'b0, '0},
        '{KIND_ADD, 2'd3, 1'b0, 1'b0, 17'd0,     1'b0, '0},
        '{KIND_ADD, 2'd2, 1'b1, 1'b0, 17'd0,     1'b0, '0},
        '{KIND_ADD, 2'd3, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd3, 3'd0, 3'd0, 1'b0}},
        '{KIND_MAP, 2'd3, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd0, 3'd0, 3'd0, 1'b0}},
        '{KIND_MAP, 2'd1, 1'b1, 1'b1, 17'd0,     1'b0, '0},
        '{KIND_MAP, 2'd0, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd2, 3'd0, 3'd0, 1'b0}},
        '{KIND_MAP, 2'd1, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd1, 3'd0, 3'd0, 1'b0}},
        '{KIND_MAP, 2'd2, 1'b0, 1'b1, 17'd0,     1'b0, '0},
        '{KIND_NONE, 2'd3, 1'b1, 1'b1, 17'h1ffff, 1'b0, '0},
        '{KIND_DEG, 2'd0, 1'b0, 1'b0, 17'd1,     1'b0, '0},
        '{KIND_DEG, 2'd0, 1'b0, 1'b0, 17'd2,     1'b0, '0},
        '{KIND_DEG, 2'd0, 1'b0, 1'b0, 17'd3,     1'b0, '0},
        '{KIND_DEG, 2'd0, 1'b0, 1'b0, 17'd4,     1'b1, '{17'd0, 3'd0, 3'd0, 1'b0}},
        '{KIND_ADD, 2'd3, 1'b1, 1'b1, 17'd0,     1'b0, '0},
        '{KIND_ADD, 2'd3, 1'b1, 1'b0, 17'd0,     1'b1, '{17'd4, 3'd0, 3'd0, 1'b0}},
        '{KIND_DEG, 2'd0, 1'b0, 1'b0, 17'd4,     1'b0, '0}
    };

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_ADD;
        in_ch.base = 2'd0;
        in_ch.base_valid = 1'b0;
        in_ch.seq_start = 1'b0;
        in_ch.query_node = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_kmer_len(5'd2);
        foreach (directed[i]) send_beat(directed[i]);
        random_phase(350);

        // zero is taken as one
        write_kmer_len(5'd0);
        random_phase(350);

        write_kmer_len(5'd31);
        random_phase(400);

        write_kmer_len(5'd5);
        random_phase(350);

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[kmer_node_table_core] OK");
        else
            $display("[kmer_node_table_core] ERROR");
        $finish;
    end

endmodule

// ----- kmer_node_table_core.f -----
+incdir+design
design/knt_pkg.sv
design/knt_if.sv
design/kmer_node_table_core.sv
tb/tb_kmer_node_table_core.sv
